@@ design/imd_pkg.sv @@
// Shared types and constants for the stream metadata deframer.
package imd_pkg;

   localparam int TEXT_MAX_DEF = 192;
   localparam int INTERVAL_W = 24;
   localparam int META_CNT_W = 12;
   localparam int LEN_W = 8;

   localparam int TITLE_KEY_LEN = 12;
   localparam int URL_KEY_LEN = 10;
   localparam logic [8*TITLE_KEY_LEN-1:0] TITLE_KEY = "StreamTitle=";
   localparam logic [8*URL_KEY_LEN-1:0] URL_KEY = "StreamUrl=";

   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   typedef enum logic [1:0] {
      KIND_IGNORED = 2'd0,
      KIND_AUDIO = 2'd1,
      KIND_LENGTH = 2'd2,
      KIND_META = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_SEARCH = 3'd0,
      PH_QUOTE = 3'd1,
      PH_CAPTURE = 3'd2,
      PH_DONE = 3'd3,
      PH_FAILED = 3'd4
   } phase_type;

   typedef struct packed {
      logic char_valid;
      logic changed;
      logic [LEN_W-1:0] length;
   } scan_out_type;

endpackage

@@ design/imd_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module imd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 382
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ design/imd_key_scan.sv @@
// Key matcher and value capture for one metadata key, with its two-bank value store.
module imd_key_scan
   import imd_pkg::*;
#(
   parameter int TEXT_MAX = TEXT_MAX_DEF,
   parameter int KEY_LEN = TITLE_KEY_LEN,
   parameter logic [8*KEY_LEN-1:0] KEY = TITLE_KEY
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [7:0]   stream_byte,
   input  logic         block_end,
   input  logic         restart,
   output scan_out_type result
);
   localparam int VAL_MAX = TEXT_MAX - 1;
   localparam int DEPTH = 2 * VAL_MAX;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(TEXT_MAX);
   localparam int PW = $clog2(KEY_LEN + 1);
   localparam logic [CW-1:0] VAL_MAX_C = CW'(VAL_MAX);
   localparam logic [AW-1:0] VAL_MAX_A = AW'(VAL_MAX);

   logic [7:0] key_chars [KEY_LEN];

   phase_type phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic quote_ff, quote_in;
   logic [CW-1:0] count_ff, count_in;
   logic differs_ff, differs_in;
   logic pend_ff, pend_in;
   logic [7:0] pend_byte_ff, pend_byte_in;
   logic bank_ff, bank_in;
   logic [CW-1:0] last_len_ff, last_len_in;

   logic we, re;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0] rd_data;
   logic [7:0] close_char;
   logic differs_eff;

   always_comb begin
      for (int i = 0; i < KEY_LEN; i++) begin
         key_chars[i] = KEY[8*(KEY_LEN-1-i) +: 8];
      end
   end

   assign wr_addr = (bank_ff ? '0 : VAL_MAX_A) + AW'(count_ff);
   assign rd_addr = (bank_ff ? VAL_MAX_A : '0) + AW'(count_ff);
   assign close_char = quote_ff ? CHAR_DQUOTE : CHAR_SQUOTE;
   assign differs_eff = differs_ff | (pend_ff & (rd_data != pend_byte_ff));

   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      quote_in = quote_ff;
      count_in = count_ff;
      differs_in = differs_eff;
      pend_in = 1'b0;
      pend_byte_in = pend_byte_ff;
      bank_in = bank_ff;
      last_len_in = last_len_ff;
      we = 1'b0;
      re = 1'b0;
      result = '0;

      if (step) begin
         case (phase_ff)
            PH_SEARCH: begin
               if (32'(pos_ff) < KEY_LEN && stream_byte == key_chars[pos_ff]) begin
                  pos_in = pos_ff + 1'b1;
                  if (32'(pos_in) == KEY_LEN) begin
                     phase_in = PH_QUOTE;
                  end
               end else begin
                  pos_in = PW'(stream_byte == key_chars[0]);
               end
            end
            PH_QUOTE: begin
               if (stream_byte == CHAR_SQUOTE || stream_byte == CHAR_DQUOTE) begin
                  quote_in = (stream_byte == CHAR_DQUOTE);
                  phase_in = PH_CAPTURE;
                  count_in = '0;
               end else begin
                  phase_in = PH_FAILED;
               end
            end
            PH_CAPTURE: begin
               if (stream_byte == close_char) begin
                  phase_in = PH_DONE;
               end else if (count_ff < VAL_MAX_C) begin
                  we = 1'b1;
                  if (count_ff < last_len_ff) begin
                     // compare against the kept value once the read returns
                     re = 1'b1;
                     pend_in = 1'b1;
                     pend_byte_in = stream_byte;
                  end else begin
                     differs_in = 1'b1;
                  end
                  count_in = count_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end

      result.char_valid = we;

      if (block_end && phase_in == PH_DONE) begin
         result.length = LEN_W'(count_in);
         if (count_in != '0 && (differs_in || count_in != last_len_ff)) begin
            result.changed = 1'b1;
            last_len_in = count_in;
            bank_in = ~bank_ff;
         end
      end

      if (restart || block_end) begin
         phase_in = PH_SEARCH;
         pos_in = '0;
         quote_in = 1'b0;
         count_in = '0;
         differs_in = 1'b0;
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         pos_ff <= '0;
         quote_ff <= 1'b0;
         count_ff <= '0;
         differs_ff <= 1'b0;
         pend_ff <= 1'b0;
         bank_ff <= 1'b0;
         last_len_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         quote_ff <= quote_in;
         count_ff <= count_in;
         differs_ff <= differs_in;
         pend_ff <= pend_in;
         bank_ff <= bank_in;
         last_len_ff <= last_len_in;
      end
      pend_byte_ff <= pend_byte_in;
   end

   imd_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (we),
      .wr_addr(wr_addr),
      .wr_data(stream_byte),
      .rd_en  (re),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );
endmodule

@@ design/icy_metadata_deframer.sv @@
// Top level of the in-band stream metadata deframer.
// Takes one stream byte per cycle unless a held result is stalled, and returns one result
// per byte, back to back, via the result register. csr_write_data sets the number of audio
// bytes between metadata blocks (0 ignores all bytes); a write restarts in the audio phase.
// Title and url values live in two-bank byte RAMs, one per key, sized 2*(TEXT_MAX-1); each
// captured character is written to the new bank while the kept bank is read at the same
// offset, and the registered read is compared in the following cycle. No clearing pass.
module icy_metadata_deframer
   import imd_pkg::*;
#(
   parameter int TEXT_MAX = TEXT_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_stream_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_byte_kind,
   output logic [7:0]            rsp_byte_echo,
   output logic                  rsp_title_char_valid,
   output logic                  rsp_url_char_valid,
   output logic                  rsp_block_end,
   output logic                  rsp_title_changed,
   output logic                  rsp_url_changed,
   output logic [LEN_W-1:0]      rsp_title_length,
   output logic [LEN_W-1:0]      rsp_url_length,
   input  logic                  csr_write_enable,
   input  logic [INTERVAL_W-1:0] csr_write_data
);
   logic [INTERVAL_W-1:0] interval_ff, interval_in;
   logic [INTERVAL_W-1:0] audio_cnt_ff, audio_cnt_in;
   logic [META_CNT_W-1:0] meta_cnt_ff, meta_cnt_in;
   logic in_meta_ff, in_meta_in;
   logic nul_seen_ff, nul_seen_in;

   logic rsp_valid_ff, rsp_valid_in;
   kind_type kind_ff, kind_in;
   logic [7:0] echo_ff;
   scan_out_type title_ff, url_ff, title_res, url_res;
   logic bend_ff, bend_in;

   logic accept, step, restart;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_comb begin
      interval_in = interval_ff;
      audio_cnt_in = audio_cnt_ff;
      meta_cnt_in = meta_cnt_ff;
      in_meta_in = in_meta_ff;
      nul_seen_in = nul_seen_ff;
      kind_in = KIND_IGNORED;
      step = 1'b0;
      bend_in = 1'b0;
      restart = 1'b0;

      if (csr_write_enable) begin
         interval_in = csr_write_data;
         audio_cnt_in = csr_write_data;
         in_meta_in = 1'b0;
         meta_cnt_in = '0;
         nul_seen_in = 1'b0;
         restart = 1'b1;
      end else if (accept && interval_ff != '0) begin
         if (in_meta_ff) begin
            kind_in = KIND_META;
            if (!nul_seen_ff) begin
               if (req_stream_byte == CHAR_NUL) begin
                  nul_seen_in = 1'b1;
               end else begin
                  step = 1'b1;
               end
            end
            meta_cnt_in = meta_cnt_ff - 1'b1;
            if (meta_cnt_ff == META_CNT_W'(1)) begin
               bend_in = 1'b1;
               in_meta_in = 1'b0;
               audio_cnt_in = interval_ff;
               nul_seen_in = 1'b0;
            end
         end else if (audio_cnt_ff != '0) begin
            kind_in = KIND_AUDIO;
            audio_cnt_in = audio_cnt_ff - 1'b1;
         end else begin
            kind_in = KIND_LENGTH;
            meta_cnt_in = {req_stream_byte, 4'b0000};
            nul_seen_in = 1'b0;
            restart = 1'b1;
            if (req_stream_byte == CHAR_NUL) begin
               audio_cnt_in = interval_ff;
            end else begin
               in_meta_in = 1'b1;
            end
         end
      end
   end

   imd_key_scan #(
      .TEXT_MAX(TEXT_MAX),
      .KEY_LEN (TITLE_KEY_LEN),
      .KEY     (TITLE_KEY)
   ) u_title (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .stream_byte(req_stream_byte),
      .block_end  (bend_in),
      .restart    (restart),
      .result     (title_res)
   );

   imd_key_scan #(
      .TEXT_MAX(TEXT_MAX),
      .KEY_LEN (URL_KEY_LEN),
      .KEY     (URL_KEY)
   ) u_url (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .stream_byte(req_stream_byte),
      .block_end  (bend_in),
      .restart    (restart),
      .result     (url_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= '0;
         audio_cnt_ff <= '0;
         meta_cnt_ff <= '0;
         in_meta_ff <= 1'b0;
         nul_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         interval_ff <= interval_in;
         audio_cnt_ff <= audio_cnt_in;
         meta_cnt_ff <= meta_cnt_in;
         in_meta_ff <= in_meta_in;
         nul_seen_ff <= nul_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // load the result register on accept, hold it while stalled
      if (accept) begin
         kind_ff <= kind_in;
         echo_ff <= req_stream_byte;
         title_ff <= title_res;
         url_ff <= url_res;
         bend_ff <= bend_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte_kind = kind_ff;
   assign rsp_byte_echo = echo_ff;
   assign rsp_title_char_valid = title_ff.char_valid;
   assign rsp_url_char_valid = url_ff.char_valid;
   assign rsp_block_end = bend_ff;
   assign rsp_title_changed = title_ff.changed;
   assign rsp_url_changed = url_ff.changed;
   assign rsp_title_length = title_ff.length;
   assign rsp_url_length = url_ff.length;
endmodule

@@ design/imd_checker.sv @@
// Port-level assertions for the deframer and their bind to the top level.
module imd_checker
   import imd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [1:0]            rsp_byte_kind,
   input logic [7:0]            rsp_byte_echo,
   input logic                  rsp_title_char_valid,
   input logic                  rsp_url_char_valid,
   input logic                  rsp_block_end,
   input logic                  rsp_title_changed,
   input logic                  rsp_url_changed,
   input logic [LEN_W-1:0]      rsp_title_length,
   input logic [LEN_W-1:0]      rsp_url_length
);
   a_change_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_title_changed || rsp_url_changed) |-> rsp_block_end)
      else $error("value change flagged outside block end");

   a_change_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_title_changed |-> rsp_title_length != '0)
      else $error("title change flagged with empty value");

   a_url_change_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_url_changed |-> rsp_url_length != '0)
      else $error("url change flagged with empty value");

   a_char_in_meta: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_title_char_valid || rsp_url_char_valid || rsp_block_end)
      |-> rsp_byte_kind == KIND_META)
      else $error("metadata flags on a non-metadata byte");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte_echo)
      && $stable(rsp_byte_kind))
      else $error("stalled request changed");
endmodule

bind icy_metadata_deframer imd_checker u_imd_checker (.*);
